>>> design/pidph_pkg.sv
package pidph_pkg;

	// Accumulator and gain format.
	localparam int ACC_WIDTH      = 32;
	localparam int GAIN_FRAC_BITS = 8;

	// Field widths.
	localparam int TEMP_W     = 14;
	localparam int ERR_W      = 14;
	localparam int SETPOINT_W = 11;
	localparam int GAIN_W     = 16;
	localparam int DELAY_W    = 14;
	localparam int WINDOW_W   = 12;
	localparam int TICKS_W    = 16;
	localparam int FAULT_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Error saturation limits.
	localparam int ERR_MAX = 8191;
	localparam int ERR_MIN = -8192;

	// Derivative scale applied before the divide by elapsed ticks.
	localparam int DERIV_SCALE = 1000;

	// Shared multiplier: signed 32 by signed 17.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Proportional term width after the fraction shift.
	localparam int P_W = GAIN_W + ERR_W + 1;

	// Derivative numerator magnitude is below 2^40; quotient width after the shift.
	localparam int NUM_MAG_W = 40;
	localparam int DQ_W      = NUM_MAG_W - GAIN_FRAC_BITS;
	localparam int DCNT_W    = $clog2(DQ_W + 1);

	// Integral update width: accumulator shifted up plus a full product.
	localparam int SUM_W = ((ACC_WIDTH + GAIN_FRAC_BITS > PROD_W) ?
		(ACC_WIDTH + GAIN_FRAC_BITS) : PROD_W) + 1;

	// Controller sum width: widest of the three terms plus carry room.
	localparam int TERM_MAX_W = (ACC_WIDTH > DQ_W + 1) ?
		((ACC_WIDTH > P_W) ? ACC_WIDTH : P_W) :
		((DQ_W + 1 > P_W) ? (DQ_W + 1) : P_W);
	localparam int TOT_W = TERM_MAX_W + 2;

	// Offsets that turn an arithmetic shift into rounding toward zero.
	localparam logic signed [PROD_W-1:0] PTRUNC_ADJ =
		PROD_W'((64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1);
	localparam logic signed [SUM_W-1:0] ITRUNC_ADJ =
		SUM_W'((64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1);

	// Integral saturation limits at the update width.
	localparam logic signed [SUM_W-1:0] ACC_MAX_EXT =
		SUM_W'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] ACC_MIN_EXT = -ACC_MAX_EXT - SUM_W'(1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd7;

	// Configuration reset values.
	localparam logic [GAIN_W-1:0]   GAIN_P_RST    = 16'd51968;
	localparam logic [DELAY_W-1:0]  MAX_DELAY_RST = 14'd7400;
	localparam logic [WINDOW_W-1:0] WINDOW_RST    = 12'd120;

	// Sensor fault code for a healthy sensor.
	localparam logic [FAULT_W-1:0] FAULT_OK = 2'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_ACC_I,
		ST_MUL_D,
		ST_MUL_K,
		ST_DIV_SET,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} state_t;

endpackage

>>> design/pidph_ifs.sv
// Measurement channel: one word per control step.
interface pidph_meas_if import pidph_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] heater_temp;
	logic signed [TEMP_W-1:0] element_temp;
	logic [FAULT_W-1:0]       heater_fault;
	logic [FAULT_W-1:0]       element_fault;
	logic [TICKS_W-1:0]       elapsed_ticks;
	logic                     zero_cross;

	modport source (
		output valid, heater_temp, element_temp, heater_fault, element_fault,
		output elapsed_ticks, zero_cross,
		input  ready
	);
	modport sink (
		input  valid, heater_temp, element_temp, heater_fault, element_fault,
		input  elapsed_ticks, zero_cross,
		output ready
	);
endinterface

// Command channel: one word per control step.
interface pidph_cmd_if import pidph_pkg::*;;
	logic               valid;
	logic               ready;
	logic [DELAY_W-1:0] drive;
	logic [DELAY_W-1:0] fire_delay;
	logic               gate_fire;
	logic [FAULT_W-1:0] sensor_fault;

	modport source (
		output valid, drive, fire_delay, gate_fire, sensor_fault,
		input  ready
	);
	modport sink (
		input  valid, drive, fire_delay, gate_fire, sensor_fault,
		output ready
	);
endinterface

>>> design/pid_phase_angle_heater.sv
// An enabled step runs through MUL_P, MUL_I, ACC_I, MUL_D, MUL_K, DIV_SET, DIV (the
// one-bit-per-cycle derivative divider, DQ_W = 32 quotient bits), SUM and OUT; with zero
// elapsed ticks the divider is skipped, and a disabled step goes straight to OUT.
// One step at a time: a new word is taken only back in IDLE, after the step has left OUT,
// and OUT is left later while the previous result word is stalled.
// Reset (arst_n low, asynchronous) loads the register reset values and clears the
// integral, the last error, the sequencer and the output valid flag.
module pid_phase_angle_heater import pidph_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	pidph_meas_if.sink            meas,
	pidph_cmd_if.source           cmd
);

	// Configuration registers.
	logic [SETPOINT_W-1:0] setpoint_q;
	logic                  enable_q;
	logic                  source_sel_q;
	logic [GAIN_W-1:0]     gain_p_q;
	logic [GAIN_W-1:0]     gain_i_q;
	logic [GAIN_W-1:0]     gain_d_q;
	logic [DELAY_W-1:0]    max_delay_q;
	logic [WINDOW_W-1:0]   window_q;

	// Controller state.
	logic signed [ACC_WIDTH-1:0] integral_q;
	logic signed [ERR_W-1:0]     last_error_q;

	// Step working registers.
	state_t                   state_q, state_d;
	logic signed [ERR_W-1:0]  e_q;
	logic [TICKS_W-1:0]       ticks_q;
	logic                     gate_q;
	logic [FAULT_W-1:0]       fault_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [P_W-1:0]    p_q;
	logic [DQ_W-1:0]          dvd_q;
	logic [TICKS_W-1:0]       rem_q;
	logic [DCNT_W-1:0]        div_cnt_q;
	logic                     d_neg_q;
	logic signed [TOT_W-1:0]  sum_q;

	// Output register.
	logic               out_valid_q;
	logic [DELAY_W-1:0] drive_q;
	logic [DELAY_W-1:0] firing_q;
	logic               gate_out_q;
	logic [FAULT_W-1:0] fault_out_q;

	// Combinational datapath signals.
	logic signed [TEMP_W:0]    temp_sel;
	logic signed [TEMP_W:0]    diff;
	logic signed [ERR_W-1:0]   e_sat;
	logic signed [ERR_W:0]     de;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  p_adj;
	logic signed [PROD_W-1:0]  p_full;
	logic signed [SUM_W-1:0]   i_sum;
	logic signed [SUM_W-1:0]   i_adj;
	logic signed [SUM_W-1:0]   i_tr;
	logic signed [ACC_WIDTH-1:0] i_sat;
	logic [PROD_W-1:0]         num_mag;
	logic [TICKS_W:0]          div_shift;
	logic [TICKS_W:0]          div_diff;
	logic signed [DQ_W:0]      d_term;
	logic signed [TOT_W-1:0]   tot;
	logic signed [TOT_W-1:0]   max_delay_ext;
	logic [DELAY_W-1:0]        drive_c;
	logic                      out_free;
	logic                      in_take;

	// Configuration write decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= '0;
			enable_q     <= 1'b0;
			source_sel_q <= 1'b0;
			gain_p_q     <= GAIN_P_RST;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			max_delay_q  <= MAX_DELAY_RST;
			window_q     <= WINDOW_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SETPOINT:   setpoint_q   <= wr_data[SETPOINT_W-1:0];
				REG_ENABLE:     enable_q     <= wr_data[0];
				REG_SOURCE_SEL: source_sel_q <= wr_data[0];
				REG_GAIN_P:     gain_p_q     <= wr_data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q     <= wr_data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q     <= wr_data[GAIN_W-1:0];
				REG_MAX_DELAY:  max_delay_q  <= wr_data[DELAY_W-1:0];
				REG_WINDOW:     window_q     <= wr_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Error from the selected sensor, saturated to the error range.
	always_comb begin
		temp_sel = source_sel_q ? (TEMP_W+1)'(meas.element_temp)
		                        : (TEMP_W+1)'(meas.heater_temp);
		diff = $signed({{(TEMP_W + 1 - SETPOINT_W){1'b0}}, setpoint_q}) - temp_sel;
		if (diff > (TEMP_W+1)'(ERR_MAX)) begin
			e_sat = ERR_W'(ERR_MAX);
		end else if (diff < (TEMP_W+1)'(ERR_MIN)) begin
			e_sat = ERR_W'(ERR_MIN);
		end else begin
			e_sat = diff[ERR_W-1:0];
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		de = (ERR_W+1)'(e_q) - (ERR_W+1)'(last_error_q);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_P: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = $signed({1'b0, gain_p_q});
			end
			ST_MUL_I: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = $signed({1'b0, gain_i_q});
			end
			ST_MUL_D: begin
				mul_a = MUL_A_W'(de);
				mul_b = $signed({1'b0, gain_d_q});
			end
			ST_MUL_K: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(DERIV_SCALE);
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// Proportional and integral terms, rounded toward zero; integral saturates.
	always_comb begin
		p_adj  = prod_q[PROD_W-1] ? PTRUNC_ADJ : '0;
		p_full = (prod_q + p_adj) >>> GAIN_FRAC_BITS;
		i_sum  = (SUM_W'(integral_q) <<< GAIN_FRAC_BITS) + SUM_W'(prod_q);
		i_adj  = i_sum[SUM_W-1] ? ITRUNC_ADJ : '0;
		i_tr   = (i_sum + i_adj) >>> GAIN_FRAC_BITS;
		if (i_tr > ACC_MAX_EXT) begin
			i_sat = ACC_MAX_EXT[ACC_WIDTH-1:0];
		end else if (i_tr < ACC_MIN_EXT) begin
			i_sat = ACC_MIN_EXT[ACC_WIDTH-1:0];
		end else begin
			i_sat = i_tr[ACC_WIDTH-1:0];
		end
	end

	// Derivative divider step and final sum with clamp.
	always_comb begin
		num_mag   = prod_q[PROD_W-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
		div_shift = {rem_q, dvd_q[DQ_W-1]};
		div_diff  = div_shift - {1'b0, ticks_q};
		d_term    = d_neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		tot       = TOT_W'(p_q) + TOT_W'(integral_q) + TOT_W'(d_term);
		max_delay_ext = $signed({{(TOT_W - DELAY_W){1'b0}}, max_delay_q});
		if (sum_q < 0) begin
			drive_c = '0;
		end else if (sum_q > max_delay_ext) begin
			drive_c = max_delay_q;
		end else begin
			drive_c = sum_q[DELAY_W-1:0];
		end
	end

	// Sequencer: next state and handshake.
	always_comb begin
		out_free   = !out_valid_q || cmd.ready;
		meas.ready = (state_q == ST_IDLE);
		in_take    = meas.valid && meas.ready;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE:    if (meas.valid) state_d = enable_q ? ST_MUL_P : ST_OUT;
			ST_MUL_P:   state_d = ST_MUL_I;
			ST_MUL_I:   state_d = ST_ACC_I;
			ST_ACC_I:   state_d = ST_MUL_D;
			ST_MUL_D:   state_d = ST_MUL_K;
			ST_MUL_K:   state_d = ST_DIV_SET;
			ST_DIV_SET: state_d = (ticks_q == '0) ? ST_SUM : ST_DIV;
			ST_DIV:     if (div_cnt_q == DCNT_W'(1)) state_d = ST_SUM;
			ST_SUM:     state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Controller state: integral and last error change only on enabled steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
		end else begin
			case (state_q)
				ST_MUL_P: begin
					if ($signed({e_q[ERR_W-1], e_q}) >
					    $signed({{(ERR_W + 1 - WINDOW_W){1'b0}}, window_q})) begin
						integral_q <= '0;
					end
				end
				ST_ACC_I:   integral_q   <= i_sat;
				ST_DIV_SET: last_error_q <= e_q;
				default: ;
			endcase
		end
	end

	// Step datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					e_q     <= e_sat;
					ticks_q <= meas.elapsed_ticks;
					gate_q  <= enable_q && meas.zero_cross;
					fault_q <= (meas.heater_fault != FAULT_OK) ? meas.heater_fault
					                                             : meas.element_fault;
					sum_q   <= '0;
				end
			end
			ST_MUL_P: prod_q <= mul_p;
			ST_MUL_I: begin
				p_q    <= p_full[P_W-1:0];
				prod_q <= mul_p;
			end
			ST_MUL_D: prod_q <= mul_p;
			ST_MUL_K: prod_q <= mul_p;
			ST_DIV_SET: begin
				d_neg_q   <= prod_q[PROD_W-1];
				dvd_q     <= (ticks_q == '0) ? '0
				             : num_mag[NUM_MAG_W-1:GAIN_FRAC_BITS];
				rem_q     <= '0;
				div_cnt_q <= DCNT_W'(DQ_W);
			end
			ST_DIV: begin
				if (!div_diff[TICKS_W]) begin
					rem_q <= div_diff[TICKS_W-1:0];
					dvd_q <= {dvd_q[DQ_W-2:0], 1'b1};
				end else begin
					rem_q <= div_shift[TICKS_W-1:0];
					dvd_q <= {dvd_q[DQ_W-2:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
			ST_SUM: sum_q <= tot;
			default: ;
		endcase
	end

	// Output register: loaded at the end of a step, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			drive_q     <= drive_c;
			firing_q    <= max_delay_q - drive_c;
			gate_out_q  <= gate_q;
			fault_out_q <= fault_q;
		end
	end

	assign cmd.valid        = out_valid_q;
	assign cmd.drive        = drive_q;
	assign cmd.fire_delay   = firing_q;
	assign cmd.gate_fire    = gate_out_q;
	assign cmd.sensor_fault = fault_out_q;

endmodule

>>> design/pidph_checker.sv
module pidph_checker import pidph_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               meas_valid,
	input logic               meas_ready,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic [DELAY_W-1:0] cmd_drive,
	input logic [DELAY_W-1:0] cmd_fire_delay,
	input logic               cmd_gate_fire,
	input logic [FAULT_W-1:0] cmd_sensor_fault
);

	// One step at a time: the block stops taking words after it accepts one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready)
		else $error("measurement accepted while a step is in progress");

	// Even the shortest step passes through the OUT state before its result shows.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !$rose(cmd_valid))
		else $error("result appeared one cycle after acceptance");

	// A stalled result word holds.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_drive) &&
		$stable(cmd_fire_delay) && $stable(cmd_gate_fire) && $stable(cmd_sensor_fault))
		else $error("result word changed while stalled");

	// Reset leaves no result pending.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !cmd_valid)
		else $error("result valid during reset");

endmodule

bind pid_phase_angle_heater pidph_checker u_pidph_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.meas_valid       (meas.valid),
	.meas_ready       (meas.ready),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_drive        (cmd.drive),
	.cmd_fire_delay   (cmd.fire_delay),
	.cmd_gate_fire    (cmd.gate_fire),
	.cmd_sensor_fault (cmd.sensor_fault)
);

>>> tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pidph_pkg::*;

	localparam int RUN_LIMIT     = 600000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_STEPS   = 50;
	localparam int WINDUP_STEPS  = 120;
	localparam int STREAM_STEPS  = 60;
	localparam int MAX_REPORTS   = 100;

	// Thermocouple fault codes besides the healthy one.
	localparam logic [FAULT_W-1:0] FAULT_OPEN      = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_SHORT_GND = 2'd2;
	localparam logic [FAULT_W-1:0] FAULT_SHORT_VCC = 2'd3;

	typedef struct packed {
		logic signed [TEMP_W-1:0] heater_temp;
		logic signed [TEMP_W-1:0] element_temp;
		logic [FAULT_W-1:0]       heater_fault;
		logic [FAULT_W-1:0]       element_fault;
		logic [TICKS_W-1:0]       elapsed_ticks;
		logic                     zero_cross;
	} meas_word_t;

	typedef struct packed {
		logic [DELAY_W-1:0] drive;
		logic [DELAY_W-1:0] fire_delay;
		logic               gate_fire;
		logic [FAULT_W-1:0] sensor_fault;
	} cmd_word_t;

	typedef struct packed {
		logic [SETPOINT_W-1:0] setpoint;
		logic                  enable;
		logic                  source_sel;
		logic [GAIN_W-1:0]     gain_p;
		logic [GAIN_W-1:0]     gain_i;
		logic [GAIN_W-1:0]     gain_d;
		logic [DELAY_W-1:0]    max_delay;
		logic [WINDOW_W-1:0]   window;
	} heater_cfg_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	pidph_meas_if meas ();
	pidph_cmd_if  cmd ();

	pid_phase_angle_heater dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.meas     (meas),
		.cmd      (cmd)
	);

	// Controller copy: settings as written, integral and previous error.
	heater_cfg_t ctl_cfg;
	longint      integ_acc;
	longint      prev_err;

	cmd_word_t expected_cmds[$];

	int  steps_sent       = 0;
	int  cmds_checked     = 0;
	int  settings_applied = 0;
	int  mismatches       = 0;
	int  cycle_count      = 0;
	int  send_gap_pct     = 20;
	int  stall_pct        = 20;
	bit  calm             = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at %0t ns, word %0d: %s", $time, cmds_checked, msg);
		mismatches++;
	endtask

	// Next command word of the controller for one measurement word.
	function automatic cmd_word_t predict_command(input meas_word_t w);
		longint    one, acc_hi, acc_lo, temp, sp, err, win, gp, gi, gd;
		longint    ticks, prop, deriv, total, drv, md, slack;
		cmd_word_t r;
		one    = longint'(1) <<< GAIN_FRAC_BITS;
		acc_hi = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
		acc_lo = -acc_hi - 1;
		md     = ctl_cfg.max_delay;
		drv    = 0;
		if (ctl_cfg.enable) begin
			if (ctl_cfg.source_sel)
				temp = $signed(w.element_temp);
			else
				temp = $signed(w.heater_temp);
			sp    = ctl_cfg.setpoint;
			win   = ctl_cfg.window;
			gp    = ctl_cfg.gain_p;
			gi    = ctl_cfg.gain_i;
			gd    = ctl_cfg.gain_d;
			ticks = w.elapsed_ticks;
			err   = sp - temp;
			if (err > ERR_MAX)
				err = ERR_MAX;
			else if (err < ERR_MIN)
				err = ERR_MIN;
			// A large error throws away the accumulated integral.
			if (err > win)
				integ_acc = 0;
			prop      = (gp * err) / one;
			integ_acc = (integ_acc * one + gi * err) / one;
			if (integ_acc > acc_hi)
				integ_acc = acc_hi;
			else if (integ_acc < acc_lo)
				integ_acc = acc_lo;
			if (ticks != 0)
				deriv = (gd * (err - prev_err) * DERIV_SCALE) / (ticks * one);
			else
				deriv = 0;
			total = prop + integ_acc + deriv;
			if (total < 0)
				drv = 0;
			else if (total > md)
				drv = md;
			else
				drv = total;
			prev_err = err;
		end
		slack          = md - drv;
		r.drive        = drv[DELAY_W-1:0];
		r.fire_delay   = slack[DELAY_W-1:0];
		r.gate_fire    = ctl_cfg.enable & w.zero_cross;
		r.sensor_fault = (w.heater_fault != FAULT_OK) ? w.heater_fault : w.element_fault;
		return r;
	endfunction

	// Every accepted command word is matched against the oldest prediction.
	always @(posedge clk) begin
		cmd_word_t got, want;
		if (arst_n === 1'b1 && cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
			got.drive        = cmd.drive;
			got.fire_delay   = cmd.fire_delay;
			got.gate_fire    = cmd.gate_fire;
			got.sensor_fault = cmd.sensor_fault;
			if (expected_cmds.size() == 0) begin
				report_mismatch("command word arrived with none expected");
			end else begin
				want = expected_cmds.pop_front();
				if (got.drive !== want.drive)
					report_mismatch($sformatf("drive got %0d want %0d",
						got.drive, want.drive));
				if (got.fire_delay !== want.fire_delay)
					report_mismatch($sformatf("fire_delay got %0d want %0d",
						got.fire_delay, want.fire_delay));
				if (got.gate_fire !== want.gate_fire)
					report_mismatch($sformatf("gate_fire got %b want %b",
						got.gate_fire, want.gate_fire));
				if (got.sensor_fault !== want.sensor_fault)
					report_mismatch($sformatf("sensor_fault got %0d want %0d",
						got.sensor_fault, want.sensor_fault));
				cmds_checked++;
			end
		end
	end

	// Command side back-pressure: random stall bursts until the final stretch.
	initial begin
		int stall;
		stall = 0;
		cmd.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall == 0 && !calm && $urandom_range(0, 99) < stall_pct)
				stall = $urandom_range(1, 11);
			if (stall > 0) begin
				cmd.ready <= 1'b0;
				stall--;
			end else begin
				cmd.ready <= 1'b1;
			end
		end
	end

	function automatic meas_word_t make_step(input int heater, input int element,
		input logic [FAULT_W-1:0] hf, input logic [FAULT_W-1:0] ef,
		input int ticks, input logic zc);
		meas_word_t w;
		w.heater_temp   = TEMP_W'(heater);
		w.element_temp  = TEMP_W'(element);
		w.heater_fault  = hf;
		w.element_fault = ef;
		w.elapsed_ticks = TICKS_W'(ticks);
		w.zero_cross    = zc;
		return w;
	endfunction

	// Offer one measurement word; valid stays up afterwards so words can follow back to back.
	task automatic send_step(input meas_word_t w);
		if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
			meas.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		meas.valid         <= 1'b1;
		meas.heater_temp   <= w.heater_temp;
		meas.element_temp  <= w.element_temp;
		meas.heater_fault  <= w.heater_fault;
		meas.element_fault <= w.element_fault;
		meas.elapsed_ticks <= w.elapsed_ticks;
		meas.zero_cross    <= w.zero_cross;
		do @(posedge clk); while (meas.ready !== 1'b1);
		expected_cmds.push_back(predict_command(w));
		steps_sent++;
	endtask

	task automatic stop_sending();
		meas.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all registers while the block is idle; unused upper data bits carry noise.
	task automatic apply_config(input heater_cfg_t c);
		logic [CFG_DATA_W-1:0] data;
		logic [CFG_IDX_W-1:0]  idx;
		stop_sending();
		wait_drained();
		for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
			idx  = CFG_IDX_W'(i);
			data = CFG_DATA_W'($urandom);
			case (idx)
				REG_SETPOINT:   data[SETPOINT_W-1:0] = c.setpoint;
				REG_ENABLE:     data[0] = c.enable;
				REG_SOURCE_SEL: data[0] = c.source_sel;
				REG_GAIN_P:     data = c.gain_p;
				REG_GAIN_I:     data = c.gain_i;
				REG_GAIN_D:     data = c.gain_d;
				REG_MAX_DELAY:  data[DELAY_W-1:0] = c.max_delay;
				REG_WINDOW:     data[WINDOW_W-1:0] = c.window;
				default:        data = data;
			endcase
			wr_en    <= 1'b1;
			wr_index <= idx;
			wr_data  <= data;
			@(posedge clk);
		end
		wr_en <= 1'b0;
		ctl_cfg = c;
		settings_applied++;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return GAIN_W'($urandom_range(0, 1023));
			3:       return GAIN_W'($urandom_range(128, 512));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic heater_cfg_t random_config();
		heater_cfg_t c;
		case ($urandom_range(0, 4))
			0:       c.setpoint = '0;
			1:       c.setpoint = '1;
			default: c.setpoint = SETPOINT_W'($urandom_range(0, 1600));
		endcase
		c.enable     = ($urandom_range(0, 4) != 0);
		c.source_sel = 1'($urandom);
		c.gain_p     = pick_gain();
		c.gain_i     = pick_gain();
		c.gain_d     = pick_gain();
		case ($urandom_range(0, 4))
			0:       c.max_delay = '0;
			1:       c.max_delay = '1;
			2:       c.max_delay = MAX_DELAY_RST;
			default: c.max_delay = DELAY_W'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0:       c.window = '0;
			1:       c.window = '1;
			2:       c.window = WINDOW_RST;
			3:       c.window = WINDOW_W'($urandom_range(0, 300));
			default: c.window = WINDOW_W'($urandom);
		endcase
		return c;
	endfunction

	// Mostly readings close to the target, now and then anything the field holds.
	function automatic int rand_temp(input int center);
		case ($urandom_range(0, 9))
			7:       return int'($urandom_range(0, 16383)) - 8192;
			8:       return $urandom_range(0, 1) ? -1080 : 7200;
			9:       return $urandom_range(0, 1) ? -8192 : 8191;
			default: return center + int'($urandom_range(0, 600)) - 300;
		endcase
	endfunction

	function automatic meas_word_t random_step();
		int                 sp, ticks;
		logic [FAULT_W-1:0] hf, ef;
		sp = ctl_cfg.setpoint;
		case ($urandom_range(0, 9))
			0:       ticks = 0;
			1:       ticks = 65535;
			7, 8:    ticks = int'($urandom_range(0, 65535));
			default: ticks = int'($urandom_range(1, 2000));
		endcase
		hf = ($urandom_range(0, 3) == 0) ? FAULT_W'($urandom) : FAULT_OK;
		ef = ($urandom_range(0, 3) == 0) ? FAULT_W'($urandom) : FAULT_OK;
		return make_step(rand_temp(sp), rand_temp(sp), hf, ef, ticks, 1'($urandom));
	endfunction

	// Reset settings leave regulation off; only the fault priority shows.
	task automatic test_disabled_defaults();
		send_step(make_step(0, 0, FAULT_OK, FAULT_OK, 0, 1'b1));
		send_step(make_step(8191, -8192, FAULT_OPEN, FAULT_SHORT_VCC, 65535, 1'b0));
		send_step(make_step(-8192, 8191, FAULT_OK, FAULT_SHORT_GND, 1, 1'b1));
		send_step(make_step(0, 0, FAULT_SHORT_VCC, FAULT_OPEN, 0, 1'b0));
	endtask

	// Saturated errors, the window boundary and the tick extremes.
	task automatic test_error_extremes();
		heater_cfg_t c;
		c = '{setpoint: 11'd1600, enable: 1'b1, source_sel: 1'b0, gain_p: GAIN_P_RST,
			gain_i: 16'd256, gain_d: 16'd256, max_delay: MAX_DELAY_RST, window: WINDOW_RST};
		apply_config(c);
		send_step(make_step(-8192, 0, FAULT_OK, FAULT_OK, 1000, 1'b1));
		send_step(make_step(8191, 0, FAULT_OK, FAULT_OPEN, 1, 1'b1));
		send_step(make_step(1600, 0, FAULT_OK, FAULT_OK, 65535, 1'b0));
		send_step(make_step(1480, 0, FAULT_OK, FAULT_OK, 0, 1'b1));
		send_step(make_step(1479, 0, FAULT_SHORT_GND, FAULT_OK, 0, 1'b1));
		send_step(make_step(1700, 0, FAULT_OK, FAULT_OK, 3, 1'b0));
		send_step(make_step(-1080, 0, FAULT_OK, FAULT_OK, 500, 1'b1));
		send_step(make_step(7200, 0, FAULT_OK, FAULT_OK, 2, 1'b1));
	endtask

	// Element sensor selected, with the heater reading pulling the other way.
	task automatic test_element_source();
		heater_cfg_t c;
		c = '{setpoint: '1, enable: 1'b1, source_sel: 1'b1, gain_p: '1, gain_i: '0,
			gain_d: '1, max_delay: '1, window: '1};
		apply_config(c);
		send_step(make_step(8191, -8192, FAULT_OK, FAULT_OK, 7, 1'b1));
		send_step(make_step(-8192, 2047, FAULT_OK, FAULT_SHORT_VCC, 65535, 1'b0));
		send_step(make_step(0, 8191, FAULT_OPEN, FAULT_OK, 100, 1'b1));
		send_step(make_step(0, 2000, FAULT_OK, FAULT_OK, 0, 1'b0));
	endtask

	// Integral and previous error must survive a disabled stretch.
	task automatic test_hold_while_disabled();
		heater_cfg_t c;
		c = '{setpoint: 11'd800, enable: 1'b1, source_sel: 1'b0, gain_p: 16'd64,
			gain_i: 16'd128, gain_d: 16'd300, max_delay: '0, window: '1};
		apply_config(c);
		send_step(make_step(700, 0, FAULT_OK, FAULT_OK, 10, 1'b1));
		send_step(make_step(600, 0, FAULT_OK, FAULT_OK, 10, 1'b1));
		c.enable = 1'b0;
		apply_config(c);
		send_step(make_step(-5000, 0, FAULT_OK, FAULT_OPEN, 1, 1'b1));
		send_step(make_step(5000, 0, FAULT_OK, FAULT_OK, 0, 1'b0));
		c.enable    = 1'b1;
		c.max_delay = '1;
		apply_config(c);
		send_step(make_step(650, 0, FAULT_OK, FAULT_OK, 10, 1'b1));
		send_step(make_step(650, 0, FAULT_OK, FAULT_OK, 20, 1'b1));
	endtask

	// Pull the integral far negative with the largest gain, then let a large error clear it.
	task automatic test_integral_windup();
		heater_cfg_t c;
		c = '{setpoint: '0, enable: 1'b1, source_sel: 1'b0, gain_p: '0, gain_i: '1,
			gain_d: '0, max_delay: '1, window: '0};
		apply_config(c);
		for (int n = 0; n < WINDUP_STEPS; n++)
			send_step(make_step(8191, int'($urandom_range(0, 16383)) - 8192,
				FAULT_W'($urandom), FAULT_W'($urandom),
				($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 65535)) : 0,
				1'($urandom)));
		for (int n = 0; n < 4; n++)
			send_step(make_step(0, 0, FAULT_OK, FAULT_OK, 0, 1'b1));
		send_step(make_step(-1, 0, FAULT_OK, FAULT_OK, 0, 1'b1));
		send_step(make_step(-1, 0, FAULT_OK, FAULT_OK, 0, 1'b1));
	endtask

	// Random settings per phase, random readings, varying gaps and stalls.
	task automatic test_random_regulation();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			apply_config(random_config());
			send_gap_pct = $urandom_range(0, 3) * 20;
			stall_pct    = $urandom_range(0, 3) * 20;
			for (int n = 0; n < PHASE_STEPS; n++) begin
				// Now and then hold off until every command word is back.
				if ($urandom_range(0, 49) == 0) begin
					stop_sending();
					wait_drained();
				end
				send_step(random_step());
			end
		end
	endtask

	// Final stretch with no idling on either side.
	task automatic test_back_to_back();
		heater_cfg_t c;
		c        = random_config();
		c.enable = 1'b1;
		apply_config(c);
		calm = 1'b1;
		for (int n = 0; n < STREAM_STEPS; n++)
			send_step(random_step());
	endtask

	initial begin
		arst_n             <= 1'b0;
		wr_en              <= 1'b0;
		wr_index           <= '0;
		wr_data            <= '0;
		meas.valid         <= 1'b0;
		meas.heater_temp   <= '0;
		meas.element_temp  <= '0;
		meas.heater_fault  <= '0;
		meas.element_fault <= '0;
		meas.elapsed_ticks <= '0;
		meas.zero_cross    <= 1'b0;
		ctl_cfg = '{setpoint: '0, enable: 1'b0, source_sel: 1'b0, gain_p: GAIN_P_RST,
			gain_i: '0, gain_d: '0, max_delay: MAX_DELAY_RST, window: WINDOW_RST};
		integ_acc = 0;
		prev_err  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_defaults();
		test_error_extremes();
		test_element_source();
		test_hold_while_disabled();
		test_integral_windup();
		test_random_regulation();
		test_back_to_back();

		// Let the last words come back, then watch for strays.
		stop_sending();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d steps under %0d register settings, %0d command words compared",
			steps_sent, settings_applied, cmds_checked);
		$display("summary: disabled hold, zero ticks, error saturation, integral windup, fault priority");
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> files.f
design/pidph_pkg.sv
design/pidph_ifs.sv
design/pid_phase_angle_heater.sv
design/pidph_checker.sv
tb/sv/tb.sv
